FILE: rtl/core/ddws_pkg.sv
// Shared constants, types and field layout of the wheel set-point shaper.
`default_nettype none
package ddws_pkg;

  localparam int HALF_TRACK_MM     = 200;
  localparam int RATE_PER_MMPS_Q16 = 196608;
  localparam int MOTOR_PERIOD_MS   = 10;
  localparam int RATE_DEN          = 65536000;

  localparam int MD_A_W = 32;
  localparam int MD_B_W = 24;
  localparam int MD_C_W = 27;
  localparam int MD_E_W = 28;
  localparam int MD_N_W = 58;
  localparam int MD_Q_W = 22;

  localparam logic [2:0] FAULT_OK      = 3'd0;
  localparam logic [2:0] FAULT_STARTUP = 3'd1;
  localparam logic [2:0] FAULT_DRIVER  = 3'd2;
  localparam logic [2:0] FAULT_FDBK    = 3'd3;
  localparam logic [2:0] FAULT_BATT    = 3'd4;
  localparam logic [2:0] FAULT_HOST    = 3'd5;

  localparam logic [2:0] REG_STARTUP_TIME = 3'd0;
  localparam logic [2:0] REG_LOCKOUT      = 3'd1;
  localparam logic [2:0] REG_BATT_CRIT    = 3'd2;
  localparam logic [2:0] REG_HOST_TMO     = 3'd3;
  localparam logic [2:0] REG_MAX_LIN      = 3'd4;
  localparam logic [2:0] REG_MAX_ANG      = 3'd5;
  localparam logic [2:0] REG_MAX_WHEEL    = 3'd6;
  localparam logic [2:0] REG_MAX_SLEW     = 3'd7;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [1:0]  drivers_healthy_mask;
    logic [3:0]  encoder_valid_mask;
    logic [3:0]  speed_valid_mask;
    logic        battery_ok_flag;
    logic [15:0] battery_mv;
    logic        handshake_done;
    logic        command_present;
    logic [31:0] command_time_ms;
    logic [31:0] startup_time_ms;
    logic [15:0] startup_lockout_ms;
    logic [15:0] battery_critical_mv;
    logic [15:0] host_timeout_ms;
  } fault_in_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/ddws_fault.sv
// Fixed-priority fault selection for one tick.
`default_nettype none
module ddws_fault import ddws_pkg::*; (
  input  fault_in_t  fin_i,
  output logic [2:0] fault_o
);

  logic [31:0] since_start;
  logic [31:0] cmd_age;

  assign since_start = fin_i.now_ms - fin_i.startup_time_ms;
  assign cmd_age     = fin_i.now_ms - fin_i.command_time_ms;

  always_comb begin
    if (since_start < {16'd0, fin_i.startup_lockout_ms}) begin
      fault_o = FAULT_STARTUP;
    end else if (fin_i.drivers_healthy_mask != 2'b11) begin
      fault_o = FAULT_DRIVER;
    end else if (fin_i.encoder_valid_mask != 4'hF || fin_i.speed_valid_mask != 4'hF) begin
      fault_o = FAULT_FDBK;
    end else if (!fin_i.battery_ok_flag || fin_i.battery_mv < fin_i.battery_critical_mv) begin
      fault_o = FAULT_BATT;
    end else if (!fin_i.handshake_done || !fin_i.command_present ||
                 cmd_age > {16'd0, fin_i.host_timeout_ms}) begin
      fault_o = FAULT_HOST;
    end else begin
      fault_o = FAULT_OK;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/ddws_muldiv.sv
// Bit-serial unit: q = (2*a*b + c) / e, saturated quotient and remainder flag.
`default_nettype none
module ddws_muldiv import ddws_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MD_A_W-1:0] a_i,
  input  logic [MD_B_W-1:0] b_i,
  input  logic [MD_C_W-1:0] c_i,
  input  logic [MD_E_W-1:0] e_i,
  output md_stat_t          stat_o,
  output logic [MD_Q_W-1:0] q_o,
  output logic              rem_nz_o
);

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_e;

  localparam int CNT_W = $clog2(MD_N_W);

  md_state_e         state_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [MD_A_W-1:0] a_q;
  logic [MD_B_W-1:0] b_q;
  logic [MD_C_W-1:0] c_q;
  logic [MD_E_W-1:0] e_q;
  logic [MD_A_W-1:0] hi_q;
  logic [MD_B_W-1:0] lo_q;
  logic [MD_N_W-1:0] n_q;
  logic [MD_E_W-1:0] rem_q;
  logic [MD_Q_W-1:0] quo_q;
  logic              ovf_q;
  logic              done_q;

  logic [MD_A_W:0]        sum;
  logic [MD_A_W+MD_B_W-1:0] prod;
  logic [MD_N_W-1:0]      numer;
  logic [MD_E_W:0]        trial;
  logic [MD_E_W:0]        diff;
  logic                   ge;

  assign sum   = {1'b0, hi_q} + (b_q[0] ? {1'b0, a_q} : '0);
  assign prod  = {sum[MD_A_W:1], sum[0], lo_q[MD_B_W-1:1]};
  assign numer = {1'b0, prod, 1'b0} + MD_N_W'(c_q);
  assign trial = {rem_q, n_q[MD_N_W-1]};
  assign diff  = trial - {1'b0, e_q};
  assign ge    = trial >= {1'b0, e_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        MD_IDLE: begin
          if (start_i) begin
            a_q     <= a_i;
            b_q     <= b_i;
            c_q     <= c_i;
            e_q     <= e_i;
            hi_q    <= '0;
            lo_q    <= '0;
            rem_q   <= '0;
            quo_q   <= '0;
            ovf_q   <= 1'b0;
            cnt_q   <= '0;
            state_q <= MD_MUL;
          end
        end
        MD_MUL: begin
          hi_q <= sum[MD_A_W:1];
          lo_q <= {sum[0], lo_q[MD_B_W-1:1]};
          b_q  <= b_q >> 1;
          if (cnt_q == CNT_W'(MD_B_W - 1)) begin
            n_q     <= numer;
            cnt_q   <= '0;
            state_q <= MD_DIV;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        MD_DIV: begin
          rem_q <= ge ? diff[MD_E_W-1:0] : trial[MD_E_W-1:0];
          quo_q <= {quo_q[MD_Q_W-2:0], ge};
          ovf_q <= ovf_q | quo_q[MD_Q_W-1];
          n_q   <= n_q << 1;
          if (cnt_q == CNT_W'(MD_N_W - 1)) begin
            done_q  <= 1'b1;
            state_q <= MD_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: state_q <= MD_IDLE;
      endcase
    end
  end

  assign stat_o.busy = state_q != MD_IDLE;
  assign stat_o.done = done_q;
  assign q_o         = ovf_q ? '1 : quo_q;
  assign rem_nz_o    = rem_q != '0;

endmodule
`default_nettype wire

FILE: rtl/core/diff_drive_wheel_setpoint_shaper_unit.sv
// Top level of the differential-drive wheel set-point shaper.
// One input beat per control tick, one result beat per input beat. A faulted tick
// skips the arithmetic. A healthy tick runs four passes through the shared bit-serial
// multiply-divide unit (limit check, left rate, right rate, slew step), each made of
// a start, 24 multiply bits, 58 divide bits and a hand-over; an output stall holds the
// result back, and the next beat is taken once the result is in the output register.
`default_nettype none
module diff_drive_wheel_setpoint_shaper_unit import ddws_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // now_ms, drivers_healthy_mask, encoder_valid_mask, speed_valid_mask,
  // battery_ok_flag, battery_mv, handshake_done, command_present,
  // command_time_ms, linear_mmps, angular_mradps
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // fault_code, drive_mode, left_wheel_rate, right_wheel_rate
  output logic [47:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  typedef enum logic [2:0] {ST_IDLE, ST_EVAL, ST_KIN, ST_OPST, ST_OPWT, ST_SLEW, ST_FIN}
    state_e;
  typedef enum logic [1:0] {OP_CMP, OP_LEFT, OP_RIGHT, OP_STEP} op_e;

  localparam logic [MD_B_W-1:0] RPM_B    = MD_B_W'(RATE_PER_MMPS_Q16);
  localparam logic [MD_C_W-1:0] DEN_C    = MD_C_W'(RATE_DEN);
  localparam logic [MD_E_W-1:0] TWO_DEN  = MD_E_W'(2 * RATE_DEN);
  localparam logic [MD_E_W-1:0] STEP_DIV = MD_E_W'(2000);
  localparam logic signed [27:0] K_LIN   = 28'sd1000;
  localparam logic signed [27:0] K_ANG   = 28'(HALF_TRACK_MM);

  logic [31:0] startup_time_q;
  logic [15:0] lockout_q;
  logic [15:0] batt_crit_q;
  logic [15:0] host_tmo_q;
  logic [14:0] max_lin_q;
  logic [14:0] max_ang_q;
  logic [19:0] max_wheel_q;
  logic [21:0] max_slew_q;

  state_e       state_q;
  op_e          op_q;
  logic [127:0] in_q;
  logic [2:0]   fault_q;
  logic [31:0]  elapsed_q;
  logic [31:0]  last_q;
  logic signed [16:0] lin_q;
  logic signed [16:0] ang_q;
  logic signed [27:0] dl_q;
  logic signed [27:0] dr_q;
  logic         over_q;
  logic [21:0]  lt_q;
  logic [21:0]  rt_q;
  logic [21:0]  step_q;
  logic signed [20:0] rate_l_q;
  logic signed [20:0] rate_r_q;
  logic         m_valid_q;
  logic [47:0]  m_data_q;

  fault_in_t   fin;
  logic [2:0]  fault_code;
  logic [31:0] now;
  logic signed [15:0] lin_in;
  logic signed [15:0] ang_in;
  logic signed [16:0] lin_lim;
  logic signed [16:0] ang_lim;
  logic signed [16:0] lin_cl;
  logic signed [16:0] ang_cl;
  logic [26:0] mag_l;
  logic [26:0] mag_r;
  logic [26:0] ud;
  logic [26:0] mag_sel;
  logic        md_start;
  logic [MD_A_W-1:0] md_a;
  logic [MD_B_W-1:0] md_b;
  logic [MD_C_W-1:0] md_c;
  logic [MD_E_W-1:0] md_e;
  md_stat_t    md_stat;
  logic [MD_Q_W-1:0] md_q;
  logic        md_rem_nz;
  logic        out_free;
  logic signed [23:0] want_l;
  logic signed [23:0] want_r;
  logic signed [23:0] slew_l;
  logic signed [23:0] slew_r;

  assign now    = in_q[31:0];
  assign lin_in = in_q[108:93];
  assign ang_in = in_q[124:109];

  assign fin.now_ms               = now;
  assign fin.drivers_healthy_mask = in_q[33:32];
  assign fin.encoder_valid_mask   = in_q[37:34];
  assign fin.speed_valid_mask     = in_q[41:38];
  assign fin.battery_ok_flag      = in_q[42];
  assign fin.battery_mv           = in_q[58:43];
  assign fin.handshake_done       = in_q[59];
  assign fin.command_present      = in_q[60];
  assign fin.command_time_ms      = in_q[92:61];
  assign fin.startup_time_ms      = startup_time_q;
  assign fin.startup_lockout_ms   = lockout_q;
  assign fin.battery_critical_mv  = batt_crit_q;
  assign fin.host_timeout_ms      = host_tmo_q;

  ddws_fault u_fault (
    .fin_i   (fin),
    .fault_o (fault_code)
  );

  assign lin_lim = $signed({2'b00, max_lin_q});
  assign ang_lim = $signed({2'b00, max_ang_q});

  always_comb begin
    lin_cl = 17'(lin_in);
    if (lin_cl > lin_lim) lin_cl = lin_lim;
    else if (lin_cl < -lin_lim) lin_cl = -lin_lim;
    ang_cl = 17'(ang_in);
    if (ang_cl > ang_lim) ang_cl = ang_lim;
    else if (ang_cl < -ang_lim) ang_cl = -ang_lim;
  end

  assign mag_l   = dl_q[27] ? 27'(-dl_q) : dl_q[26:0];
  assign mag_r   = dr_q[27] ? 27'(-dr_q) : dr_q[26:0];
  assign ud      = (mag_l > mag_r) ? mag_l : mag_r;
  assign mag_sel = (op_q == OP_LEFT) ? mag_l : mag_r;

  always_comb begin
    md_a = MD_A_W'(ud);
    md_b = RPM_B;
    md_c = '0;
    md_e = TWO_DEN;
    case (op_q)
      OP_CMP: begin
        md_a = MD_A_W'(ud);
      end
      OP_LEFT, OP_RIGHT: begin
        md_a = MD_A_W'(mag_sel);
        if (over_q) begin
          md_b = MD_B_W'(max_wheel_q);
          md_c = ud;
          md_e = {ud, 1'b0};
        end else begin
          md_c = DEN_C;
        end
      end
      OP_STEP: begin
        md_a = elapsed_q;
        md_b = MD_B_W'(max_slew_q);
        md_e = STEP_DIV;
      end
      default: md_a = MD_A_W'(ud);
    endcase
  end

  assign md_start = state_q == ST_OPST;

  ddws_muldiv u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (md_start),
    .a_i      (md_a),
    .b_i      (md_b),
    .c_i      (md_c),
    .e_i      (md_e),
    .stat_o   (md_stat),
    .q_o      (md_q),
    .rem_nz_o (md_rem_nz)
  );

  always_comb begin
    logic [19:0] ml;
    logic [19:0] mr;
    ml = (lt_q > {2'b00, max_wheel_q}) ? max_wheel_q : lt_q[19:0];
    mr = (rt_q > {2'b00, max_wheel_q}) ? max_wheel_q : rt_q[19:0];
    want_l = dl_q[27] ? -$signed({4'd0, ml}) : $signed({4'd0, ml});
    want_r = dr_q[27] ? -$signed({4'd0, mr}) : $signed({4'd0, mr});
  end

  function automatic logic signed [23:0] slew(input logic signed [23:0] cur,
                                              input logic signed [23:0] want,
                                              input logic [21:0] step);
    logic signed [23:0] up;
    logic signed [23:0] dn;
    up = cur + $signed({2'b00, step});
    dn = cur - $signed({2'b00, step});
    if (want > up) return up;
    else if (want < dn) return dn;
    else return want;
  endfunction

  assign slew_l = slew(24'(rate_l_q), want_l, step_q);
  assign slew_r = slew(24'(rate_r_q), want_r, step_q);

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      startup_time_q <= '0;
      lockout_q      <= 16'd1000;
      batt_crit_q    <= 16'd20000;
      host_tmo_q     <= 16'd500;
      max_lin_q      <= 15'd1000;
      max_ang_q      <= 15'd2000;
      max_wheel_q    <= 20'd10000;
      max_slew_q     <= 22'd20000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STARTUP_TIME: startup_time_q <= cfg_data_i;
        REG_LOCKOUT:      lockout_q      <= cfg_data_i[15:0];
        REG_BATT_CRIT:    batt_crit_q    <= cfg_data_i[15:0];
        REG_HOST_TMO:     host_tmo_q     <= cfg_data_i[15:0];
        REG_MAX_LIN:      max_lin_q      <= cfg_data_i[14:0];
        REG_MAX_ANG:      max_ang_q      <= cfg_data_i[14:0];
        REG_MAX_WHEEL:    max_wheel_q    <= cfg_data_i[19:0];
        REG_MAX_SLEW:     max_slew_q     <= cfg_data_i[21:0];
        default:          max_slew_q     <= max_slew_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= OP_CMP;
      fault_q   <= FAULT_OK;
      last_q    <= '0;
      rate_l_q  <= '0;
      rate_r_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            in_q    <= s_axis_tdata;
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          fault_q   <= fault_code;
          elapsed_q <= (last_q == '0) ? 32'(MOTOR_PERIOD_MS) : now - last_q;
          lin_q     <= lin_cl;
          ang_q     <= ang_cl;
          state_q   <= (fault_code != FAULT_OK) ? ST_FIN : ST_KIN;
        end
        ST_KIN: begin
          dl_q    <= 28'(lin_q) * K_LIN - 28'(ang_q) * K_ANG;
          dr_q    <= 28'(lin_q) * K_LIN + 28'(ang_q) * K_ANG;
          op_q    <= OP_CMP;
          state_q <= ST_OPST;
        end
        ST_OPST: begin
          state_q <= ST_OPWT;
        end
        ST_OPWT: begin
          if (md_stat.done) begin
            case (op_q)
              OP_CMP: over_q <= (md_q > {2'b00, max_wheel_q}) ||
                                (md_q == {2'b00, max_wheel_q} && md_rem_nz);
              OP_LEFT:  lt_q <= md_q;
              OP_RIGHT: rt_q <= md_q;
              OP_STEP:  step_q <= (md_q == '0) ? 22'd1 : md_q;
              default:  step_q <= md_q;
            endcase
            if (op_q == OP_STEP) begin
              state_q <= ST_SLEW;
            end else begin
              op_q    <= op_e'(op_q + 2'd1);
              state_q <= ST_OPST;
            end
          end
        end
        ST_SLEW: begin
          rate_l_q <= slew_l[20:0];
          rate_r_q <= slew_r[20:0];
          state_q  <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            last_q    <= now;
            m_valid_q <= 1'b1;
            if (fault_q != FAULT_OK) begin
              rate_l_q <= '0;
              rate_r_q <= '0;
              m_data_q <= {2'b00, 21'd0, 21'd0, 1'b0, fault_q};
            end else begin
              m_data_q <= {2'b00, rate_r_q, rate_l_q, 1'b1, FAULT_OK};
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_start |-> !md_stat.busy)
    else $error("multiply-divide started while busy");
  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == ST_EVAL)
    else $error("accepted beat not evaluated");
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN && fault_q != FAULT_OK && out_free
    |=> m_axis_tvalid && rate_l_q == '0 && rate_r_q == '0)
    else $error("fault tick left wheel rates non-zero");
  a_step_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SLEW |-> step_q != '0)
    else $error("slew step is zero");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking regression bench for the differential-drive wheel set-point shaper.
`default_nettype none
module tb_top import ddws_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 4000000;
  localparam int     DRAIN_CYCLES = 450;

  typedef struct {
    logic [31:0]        now;
    logic [1:0]         drv;
    logic [3:0]         enc;
    logic [3:0]         spd;
    logic               batt_ok;
    logic [15:0]        batt_mv;
    logic               hs;
    logic               cmd;
    logic [31:0]        cmd_time;
    logic signed [15:0] lin;
    logic signed [15:0] ang;
  } tick_t;

  typedef struct {
    logic [2:0]         fault;
    logic               mode;
    logic signed [20:0] left;
    logic signed [20:0] right;
  } setpoint_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [47:0]  m_axis_tdata;
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [31:0]  cfg_data_i;

  // shadow limits and wheel state
  logic [31:0] lim_startup, lim_lockout, lim_batt, lim_tmo;
  logic [31:0] lim_lin, lim_ang, lim_wheel, lim_slew;
  longint      left_rate, right_rate;
  logic [31:0] last_update;

  setpoint_t   pending_setpoints[$];
  int          mismatch_count;
  longint      cycle_count;
  int          src_idle_pct;
  int          rcv_stall_pct;
  logic [31:0] tick_now;

  diff_drive_wheel_setpoint_shaper_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint clamp_sym(longint v, longint lim);
    if (v < -lim) return -lim;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic longint abs_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint div_round(longint n, longint d);
    longint m;
    m = (2 * abs_l(n) + d) / (2 * d);
    return (n < 0) ? -m : m;
  endfunction

  function automatic longint slew_toward(longint cur, longint want, longint step);
    if (want > cur + step) return cur + step;
    if (want < cur - step) return cur - step;
    return want;
  endfunction

  function automatic logic [2:0] select_fault(tick_t t);
    logic [31:0] since_start;
    logic [31:0] cmd_age;
    since_start = t.now - lim_startup;
    cmd_age = t.now - t.cmd_time;
    if (since_start < lim_lockout) return FAULT_STARTUP;
    if (t.drv != 2'b11) return FAULT_DRIVER;
    if (t.enc != 4'hF || t.spd != 4'hF) return FAULT_FDBK;
    if (!t.batt_ok || t.batt_mv < lim_batt) return FAULT_BATT;
    if (!t.hs || !t.cmd || cmd_age > lim_tmo) return FAULT_HOST;
    return FAULT_OK;
  endfunction

  function automatic setpoint_t predict_setpoint(tick_t t);
    setpoint_t   r;
    logic [31:0] dt;
    longint      elapsed, lin, ang, dl, dr, nl, nr, lim, big, ud, lt, rt, step;
    r.fault = select_fault(t);
    if (r.fault != FAULT_OK) begin
      left_rate = 0;
      right_rate = 0;
      last_update = t.now;
      r.mode = 1'b0;
      r.left = '0;
      r.right = '0;
      return r;
    end
    dt = t.now - last_update;
    elapsed = (last_update == 0) ? longint'(MOTOR_PERIOD_MS) : longint'(dt);
    last_update = t.now;
    lin = clamp_sym(longint'(t.lin), longint'(lim_lin));
    ang = clamp_sym(longint'(t.ang), longint'(lim_ang));
    dl = lin * 1000 - ang * HALF_TRACK_MM;
    dr = lin * 1000 + ang * HALF_TRACK_MM;
    nl = dl * RATE_PER_MMPS_Q16;
    nr = dr * RATE_PER_MMPS_Q16;
    lim = longint'(lim_wheel);
    big = (abs_l(nl) > abs_l(nr)) ? abs_l(nl) : abs_l(nr);
    if (big > lim * RATE_DEN) begin
      ud = (abs_l(dl) > abs_l(dr)) ? abs_l(dl) : abs_l(dr);
      lt = div_round(dl * lim, ud);
      rt = div_round(dr * lim, ud);
    end else begin
      lt = div_round(nl, RATE_DEN);
      rt = div_round(nr, RATE_DEN);
    end
    lt = clamp_sym(lt, lim);
    rt = clamp_sym(rt, lim);
    step = (longint'(lim_slew) * elapsed) / 1000;
    if (step < 1) step = 1;
    left_rate = slew_toward(left_rate, lt, step);
    right_rate = slew_toward(right_rate, rt, step);
    r.mode = 1'b1;
    r.left = left_rate[20:0];
    r.right = right_rate[20:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    setpoint_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("diff_drive_wheel_setpoint_shaper_unit regression: fail");
      $finish;
    end
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_setpoints.size() == 0) begin
          report_mismatch("unexpected beat, fault", m_axis_tdata[2:0], -1);
        end else begin
          want = pending_setpoints.pop_front();
          if (m_axis_tdata[2:0] != want.fault)
            report_mismatch("fault_code", m_axis_tdata[2:0], want.fault);
          if (m_axis_tdata[3] != want.mode)
            report_mismatch("drive_mode", m_axis_tdata[3], want.mode);
          if (m_axis_tdata[24:4] != want.left)
            report_mismatch("left_wheel_rate", $signed(m_axis_tdata[24:4]), want.left);
          if (m_axis_tdata[45:25] != want.right)
            report_mismatch("right_wheel_rate", $signed(m_axis_tdata[45:25]), want.right);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  task automatic send_tick(tick_t t);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b0, t.ang, t.lin, t.cmd_time, t.cmd, t.hs, t.batt_mv, t.batt_ok,
                     t.spd, t.enc, t.drv, t.now};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_setpoints.push_back(predict_setpoint(t));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_setpoints.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      REG_STARTUP_TIME: lim_startup = val;
      REG_LOCKOUT:      lim_lockout = val & 32'hFFFF;
      REG_BATT_CRIT:    lim_batt = val & 32'hFFFF;
      REG_HOST_TMO:     lim_tmo = val & 32'hFFFF;
      REG_MAX_LIN:      lim_lin = val & 32'h7FFF;
      REG_MAX_ANG:      lim_ang = val & 32'h7FFF;
      REG_MAX_WHEEL:    lim_wheel = val & 32'hFFFFF;
      default:          lim_slew = val & 32'h3FFFFF;
    endcase
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic tick_t healthy_tick(logic [31:0] now, logic signed [15:0] lin,
                                         logic signed [15:0] ang);
    tick_t t;
    t.now = now;
    t.drv = 2'b11;
    t.enc = 4'hF;
    t.spd = 4'hF;
    t.batt_ok = 1'b1;
    t.batt_mv = 16'd30000;
    t.hs = 1'b1;
    t.cmd = 1'b1;
    t.cmd_time = now;
    t.lin = lin;
    t.ang = ang;
    return t;
  endfunction

  function automatic tick_t noise_tick();
    tick_t t;
    t.now = $urandom;
    t.drv = 2'($urandom);
    t.enc = 4'($urandom);
    t.spd = 4'($urandom);
    t.batt_ok = 1'($urandom);
    t.batt_mv = 16'($urandom);
    t.hs = 1'($urandom);
    t.cmd = 1'($urandom);
    t.cmd_time = $urandom;
    t.lin = 16'($urandom);
    t.ang = 16'($urandom);
    return t;
  endfunction

  function automatic tick_t random_command();
    tick_t t;
    int    pick;
    pick = $urandom_range(99);
    if (pick < 3) tick_now = tick_now + $urandom_range(1000, 70000);
    else if (pick < 8) tick_now = tick_now;
    else tick_now = tick_now + $urandom_range(1, 60);
    t = healthy_tick(tick_now, 16'($urandom), 16'($urandom));
    case ($urandom_range(3))
      0: begin
        t.lin = 16'($urandom_range(2 * lim_lin) - lim_lin);
        t.ang = 16'($urandom_range(2 * lim_ang) - lim_ang);
      end
      1: begin
        t.lin = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        t.ang = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      end
      default: ;
    endcase
    t.cmd_time = tick_now - $urandom_range(lim_tmo);
    t.batt_mv = 16'($urandom_range(65535, lim_batt));
    return t;
  endfunction

  function automatic tick_t broken_command();
    tick_t t;
    t = random_command();
    case ($urandom_range(5))
      0: t.drv = 2'($urandom_range(2));
      1: t.enc = 4'($urandom_range(14));
      2: t.spd = 4'($urandom_range(14));
      3: t.batt_ok = 1'b0;
      4: t.hs = 1'b0;
      default: t.cmd = 1'b0;
    endcase
    return t;
  endfunction

  task automatic apply_random_limits();
    write_reg(REG_STARTUP_TIME, $urandom);
    write_reg(REG_LOCKOUT, $urandom_range(65535));
    write_reg(REG_BATT_CRIT, $urandom_range(65535));
    write_reg(REG_HOST_TMO, $urandom_range(1) ? $urandom_range(1000) : $urandom_range(65535));
    write_reg(REG_MAX_LIN, $urandom_range(1) ? $urandom_range(2000) : $urandom_range(32767));
    write_reg(REG_MAX_ANG, $urandom_range(1) ? $urandom_range(4000) : $urandom_range(32767));
    write_reg(REG_MAX_WHEEL, $urandom_range(1) ? $urandom_range(20000) : $urandom);
    write_reg(REG_MAX_SLEW, $urandom_range(1) ? $urandom_range(50000) : $urandom);
    tick_now = lim_startup + lim_lockout + $urandom_range(1, 5000);
  endtask

  task automatic test_fault_priority();
    tick_t t;
    send_tick(healthy_tick(32'd500, 16'sd100, 16'sd0));
    t = healthy_tick(32'd0, 16'sd0, 16'sd0);
    t.drv = 2'b00; t.enc = 4'h0; t.spd = 4'h0; t.batt_ok = 1'b0; t.hs = 1'b0; t.cmd = 1'b0;
    send_tick(t);
    send_tick(healthy_tick(32'd2000, 16'sd100, 16'sd0));
    t = healthy_tick(32'd2010, 16'sd0, 16'sd0); t.drv = 2'b01; t.enc = 4'h7; send_tick(t);
    t = healthy_tick(32'd2020, 16'sd0, 16'sd0); t.enc = 4'hE; send_tick(t);
    t = healthy_tick(32'd2030, 16'sd0, 16'sd0); t.spd = 4'hB; t.batt_ok = 1'b0; send_tick(t);
    t = healthy_tick(32'd2040, 16'sd0, 16'sd0); t.batt_ok = 1'b0; send_tick(t);
    t = healthy_tick(32'd2050, 16'sd0, 16'sd0); t.batt_mv = 16'd19999; t.hs = 1'b0;
    send_tick(t);
    t = healthy_tick(32'd2060, 16'sd500, 16'sd0); t.batt_mv = 16'd20000; send_tick(t);
    t = healthy_tick(32'd2070, 16'sd0, 16'sd0); t.hs = 1'b0; send_tick(t);
    t = healthy_tick(32'd2080, 16'sd0, 16'sd0); t.cmd = 1'b0; send_tick(t);
    t = healthy_tick(32'd3000, 16'sd900, 16'sd0); t.cmd_time = 32'd2499; send_tick(t);
    t = healthy_tick(32'd3100, 16'sd900, 16'sd0); t.cmd_time = 32'd2600; send_tick(t);
    drain();
  endtask

  task automatic test_kinematics();
    send_tick(healthy_tick(32'd3200, 16'sh7FFF, 16'sd0));
    send_tick(healthy_tick(32'd3500, 16'sh8000, 16'sd0));
    send_tick(healthy_tick(32'd4000, 16'sd0, 16'sh7FFF));
    send_tick(healthy_tick(32'd4500, 16'sh8000, 16'sh8000));
    send_tick(healthy_tick(32'd4501, 16'sh7FFF, 16'sh8000));
    drain();
  endtask

  task automatic test_limit_extremes();
    tick_t t;
    write_reg(REG_STARTUP_TIME, 32'hFFFF_FF00);
    write_reg(REG_LOCKOUT, 32'd65535);
    send_tick(healthy_tick(32'h0000_0100, 16'sd100, 16'sd0));
    drain();
    write_reg(REG_LOCKOUT, 32'd0);
    write_reg(REG_MAX_WHEEL, 32'd1000);
    write_reg(REG_MAX_SLEW, 32'd0);
    t = healthy_tick(32'd5, 16'sd1000, 16'sd2000); t.cmd_time = 32'hFFFF_FFFB; send_tick(t);
    send_tick(healthy_tick(32'd6, 16'sd1000, -16'sd2000));
    drain();
    write_reg(REG_MAX_LIN, 32'd32767);
    write_reg(REG_MAX_ANG, 32'd32767);
    write_reg(REG_MAX_WHEEL, 32'hFFFFF);
    write_reg(REG_MAX_SLEW, 32'h3FFFFF);
    write_reg(REG_HOST_TMO, 32'd0);
    write_reg(REG_BATT_CRIT, 32'd65535);
    t = healthy_tick(32'd70000, 16'sh7FFF, 16'sh7FFF); t.batt_mv = 16'hFFFF; send_tick(t);
    t = healthy_tick(32'd70001, 16'sh8000, 16'sh7FFF); t.batt_mv = 16'hFFFF;
    t.cmd_time = 32'd70000; send_tick(t);
    t = healthy_tick(32'd70002, 16'sh8000, 16'sh7FFF); t.batt_mv = 16'hFFFF; send_tick(t);
    drain();
    write_reg(REG_HOST_TMO, 32'd65535);
    write_reg(REG_BATT_CRIT, 32'd0);
    write_reg(REG_MAX_WHEEL, 32'd0);
    t = healthy_tick(32'd0, 16'sd500, 16'sd500); t.batt_mv = 16'd0;
    t.cmd_time = 32'hFFFF_0001; send_tick(t);
    send_tick(healthy_tick(32'd80000, 16'sd500, 16'sd500));
    drain();
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int count);
    int pick;
    src_idle_pct = idle_pct;
    rcv_stall_pct = stall_pct;
    apply_random_limits();
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        drain();
        apply_random_limits();
      end
      pick = $urandom_range(99);
      if (pick < 75) send_tick(random_command());
      else if (pick < 87) send_tick(broken_command());
      else send_tick(noise_tick());
    end
    drain();
  endtask

  task automatic test_paused_source();
    src_idle_pct = 0;
    rcv_stall_pct = 50;
    for (int i = 0; i < 20; i++) begin
      send_tick(random_command());
      if (i % 5 == 4) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (pending_setpoints.size() != 0) @(posedge clk_i);
      end
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_STARTUP_TIME;
    cfg_data_i = '0;
    cycle_count = 0;
    mismatch_count = 0;
    src_idle_pct = 0;
    rcv_stall_pct = 0;
    lim_startup = 0;
    lim_lockout = 1000;
    lim_batt = 20000;
    lim_tmo = 500;
    lim_lin = 1000;
    lim_ang = 2000;
    lim_wheel = 10000;
    lim_slew = 20000;
    left_rate = 0;
    right_rate = 0;
    last_update = 0;
    tick_now = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fault_priority();
    test_kinematics();
    test_limit_extremes();
    test_paused_source();
    test_random_phase(0, 0, 330);
    test_random_phase(82, 0, 330);
    test_random_phase(0, 82, 330);
    test_random_phase(8, 8, 330);

    if (mismatch_count == 0) begin
      $display("diff_drive_wheel_setpoint_shaper_unit regression: pass");
    end else begin
      $display("diff_drive_wheel_setpoint_shaper_unit regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
rtl/core/ddws_pkg.sv
rtl/core/ddws_fault.sv
rtl/core/ddws_muldiv.sv
rtl/core/diff_drive_wheel_setpoint_shaper_unit.sv
tb/sv/tb_top.sv
